@@ hdl/stq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types and codes for the sorted timer queue: request opcodes,
// response status codes, response kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package stq_pkg;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_TICK   = 2'd3
   } req_op_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef enum logic [2:0] {
      OUT_ADD       = 3'd0,
      OUT_FULL      = 3'd1,
      OUT_DELETE    = 3'd2,
      OUT_NOTFOUND  = 3'd3,
      OUT_EMPTY     = 3'd4,
      OUT_QUERY     = 3'd5,
      OUT_POP       = 3'd6,
      OUT_NONE_DUE  = 3'd7
   } out_kind_type;

   typedef struct packed {
      logic         capture;
      logic         ins;
      logic         del;
      logic         pop;
      logic         out_write;
      out_kind_type out_kind;
   } stq_cmd_type;

   typedef struct packed {
      req_op_type op;
      logic       full;
      logic       empty;
      logic       found;
      logic       head_due;
      logic       pop_last;
      logic       out_free;
   } stq_status_type;

endpackage
`default_nettype wire

@@ hdl/stq_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ctrl
// Controller for the sorted timer queue: takes one request transaction at a
// time, sequences the table update and the response writes.
// ----------------------------------------------------------------------------
module stq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire stq_pkg::stq_status_type ctrl_status,
   output stq_pkg::stq_cmd_type       ctrl_cmd
);
   import stq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_POP  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctrl_cmd  = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctrl_cmd.capture = 1'b1;
               state_in         = S_EXEC;
            end
         end
         S_EXEC: begin
            if (ctrl_status.out_free) begin
               state_in = S_IDLE;
               case (ctrl_status.op)
                  CMD_ADD: begin
                     ctrl_cmd.out_write = 1'b1;
                     if (ctrl_status.full) begin
                        ctrl_cmd.out_kind = OUT_FULL;
                     end else begin
                        ctrl_cmd.ins      = 1'b1;
                        ctrl_cmd.out_kind = OUT_ADD;
                     end
                  end
                  CMD_DELETE: begin
                     ctrl_cmd.out_write = 1'b1;
                     if (ctrl_status.empty) begin
                        ctrl_cmd.out_kind = OUT_EMPTY;
                     end else if (!ctrl_status.found) begin
                        ctrl_cmd.out_kind = OUT_NOTFOUND;
                     end else begin
                        ctrl_cmd.del      = 1'b1;
                        ctrl_cmd.out_kind = OUT_DELETE;
                     end
                  end
                  CMD_QUERY: begin
                     ctrl_cmd.out_write = 1'b1;
                     ctrl_cmd.out_kind  = OUT_QUERY;
                  end
                  CMD_TICK: begin
                     ctrl_cmd.out_write = 1'b1;
                     if (ctrl_status.head_due) begin
                        ctrl_cmd.pop      = 1'b1;
                        ctrl_cmd.out_kind = OUT_POP;
                        if (!ctrl_status.pop_last) begin
                           state_in = S_POP;
                        end
                     end else begin
                        ctrl_cmd.out_kind = OUT_NONE_DUE;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_POP: begin
            if (ctrl_status.out_free) begin
               ctrl_cmd.pop       = 1'b1;
               ctrl_cmd.out_write = 1'b1;
               ctrl_cmd.out_kind  = OUT_POP;
               if (ctrl_status.pop_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/stq_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stq_datapath
// Sorted cell row of timers with per-cell compare, request registers and the
// response register. Cells shift right on insert and left on delete or pop.
// ----------------------------------------------------------------------------
module stq_datapath #(
   parameter int DEPTH         = 16,
   parameter int DEADLINE_BITS = 32,
   parameter int ID_BITS       = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire stq_pkg::stq_cmd_type   ctrl_cmd,
   output stq_pkg::stq_status_type     ctrl_status,
   input  wire logic [1:0]             req_cmd,
   input  wire logic [31:0]            req_deadline,
   input  wire logic [31:0]            req_payload,
   input  wire logic [15:0]            req_timer_id,
   input  wire logic [31:0]            req_now,
   input  wire logic                   rsp_ready,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [15:0]                 rsp_result_id,
   output logic [31:0]                 rsp_result_payload,
   output logic                        rsp_expired,
   output logic                        rsp_pending,
   output logic                        rsp_new_head,
   output logic                        rsp_last
);
   import stq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   // cell row
   logic [DEADLINE_BITS-1:0] dl_ff  [DEPTH];
   logic [DEADLINE_BITS-1:0] dl_in  [DEPTH];
   logic [ID_BITS-1:0]       id_ff  [DEPTH];
   logic [ID_BITS-1:0]       id_in  [DEPTH];
   logic [31:0]              pay_ff [DEPTH];
   logic [31:0]              pay_in [DEPTH];

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;

   // captured request
   req_op_type               op_ff;
   logic [DEADLINE_BITS-1:0] rdl_ff;
   logic [31:0]              rpay_ff;
   logic [ID_BITS-1:0]       rid_ff;
   logic [DEADLINE_BITS-1:0] now_ff;
   logic [DEPTH-1:0]         lt_ff, lt_in;
   logic [DEPTH-1:0]         match_ff, match_in;

   logic [63:0]              deadline_ext, now_ext;
   logic [31:0]              timer_id_ext;
   logic [DEADLINE_BITS-1:0] new_dl, new_now;
   logic [ID_BITS-1:0]       new_id;

   logic [DEPTH-1:0] below_mask, del_shift;

   // response register
   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [15:0] result_id_ff, result_id_in;
   logic [31:0] result_payload_ff, result_payload_in;
   logic        expired_ff, expired_in;
   logic        pending_ff, pending_in;
   logic        new_head_ff, new_head_in;
   logic        last_ff, last_in;

   logic [ID_BITS-1:0] out_id;
   logic [31:0]        out_id_ext;

   logic head_due, pop_last;

   assign deadline_ext = 64'(req_deadline);
   assign now_ext      = 64'(req_now);
   assign timer_id_ext = 32'(req_timer_id);
   assign new_dl       = deadline_ext[DEADLINE_BITS-1:0];
   assign new_now      = now_ext[DEADLINE_BITS-1:0];
   assign new_id       = timer_id_ext[ID_BITS-1:0];

   // cells from the first matching id onward move one place toward the head
   assign below_mask = match_ff ^ (match_ff - {{(DEPTH-1){1'b0}}, 1'b1});
   assign del_shift  = ~below_mask | match_ff;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DEADLINE_BITS-1:0] prev_dl, next_dl;
      logic [ID_BITS-1:0]       prev_id, next_id;
      logic [31:0]              prev_pay, next_pay;
      logic                     prev_lt;
      logic                     live;

      assign live        = count_ff > CNT_W'(i);
      assign lt_in[i]    = live && (dl_ff[i] < new_dl);
      assign match_in[i] = live && (id_ff[i] == new_id);

      if (i == 0) begin : g_head
         assign prev_dl  = rdl_ff;
         assign prev_id  = next_id_ff;
         assign prev_pay = rpay_ff;
         assign prev_lt  = 1'b1;
      end else begin : g_body
         assign prev_dl  = dl_ff[i-1];
         assign prev_id  = id_ff[i-1];
         assign prev_pay = pay_ff[i-1];
         assign prev_lt  = lt_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign next_dl  = dl_ff[i];
         assign next_id  = id_ff[i];
         assign next_pay = pay_ff[i];
      end else begin : g_mid
         assign next_dl  = dl_ff[i+1];
         assign next_id  = id_ff[i+1];
         assign next_pay = pay_ff[i+1];
      end

      always_comb begin
         dl_in[i]  = dl_ff[i];
         id_in[i]  = id_ff[i];
         pay_in[i] = pay_ff[i];
         if (ctrl_cmd.ins && !lt_ff[i]) begin
            if (prev_lt) begin
               dl_in[i]  = rdl_ff;
               id_in[i]  = next_id_ff;
               pay_in[i] = rpay_ff;
            end else begin
               dl_in[i]  = prev_dl;
               id_in[i]  = prev_id;
               pay_in[i] = prev_pay;
            end
         end else if (ctrl_cmd.pop || (ctrl_cmd.del && del_shift[i])) begin
            dl_in[i]  = next_dl;
            id_in[i]  = next_id;
            pay_in[i] = next_pay;
         end
      end

      always_ff @(posedge clock) begin
         dl_ff[i]  <= dl_in[i];
         id_ff[i]  <= id_in[i];
         pay_ff[i] <= pay_in[i];
      end
   end

   assign head_due = (count_ff != '0) && (dl_ff[0] <= now_ff);
   assign pop_last = (count_ff == CNT_W'(1)) || (dl_ff[1] > now_ff);

   always_comb begin
      count_in   = count_ff;
      next_id_in = next_id_ff;
      if (ctrl_cmd.ins) begin
         count_in   = count_ff + CNT_W'(1);
         next_id_in = next_id_ff + ID_BITS'(1);
      end else if (ctrl_cmd.del || ctrl_cmd.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         next_id_ff <= '0;
      end else begin
         count_ff   <= count_in;
         next_id_ff <= next_id_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.capture) begin
         op_ff    <= req_op_type'(req_cmd);
         rdl_ff   <= new_dl;
         rpay_ff  <= req_payload;
         rid_ff   <= new_id;
         now_ff   <= new_now;
         lt_ff    <= lt_in;
         match_ff <= match_in;
      end
   end

   always_comb begin
      status_in         = ST_OK;
      out_id            = '0;
      result_payload_in = '0;
      expired_in        = 1'b0;
      pending_in        = 1'b0;
      new_head_in       = 1'b0;
      last_in           = 1'b1;
      case (ctrl_cmd.out_kind)
         OUT_ADD: begin
            out_id      = next_id_ff;
            new_head_in = !lt_ff[0];
         end
         OUT_FULL: begin
            status_in = ST_FULL;
         end
         OUT_DELETE: begin
            out_id = rid_ff;
         end
         OUT_NOTFOUND: begin
            status_in = ST_NOTFOUND;
         end
         OUT_EMPTY: begin
            status_in = ST_EMPTY;
         end
         OUT_QUERY: begin
            pending_in = |match_ff;
         end
         OUT_POP: begin
            out_id            = id_ff[0];
            result_payload_in = pay_ff[0];
            expired_in        = 1'b1;
            last_in           = pop_last;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign out_id_ext   = 32'(out_id);
   assign result_id_in = out_id_ext[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_cmd.out_write) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_cmd.out_write) begin
         status_ff         <= status_in;
         result_id_ff      <= result_id_in;
         result_payload_ff <= result_payload_in;
         expired_ff        <= expired_in;
         pending_ff        <= pending_in;
         new_head_ff       <= new_head_in;
         last_ff           <= last_in;
      end
   end

   assign ctrl_status.op       = op_ff;
   assign ctrl_status.full     = count_ff == CNT_W'(DEPTH);
   assign ctrl_status.empty    = count_ff == '0;
   assign ctrl_status.found    = |match_ff;
   assign ctrl_status.head_due = head_due;
   assign ctrl_status.pop_last = pop_last;
   assign ctrl_status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_result_id      = result_id_ff;
   assign rsp_result_payload = result_payload_ff;
   assign rsp_expired        = expired_ff;
   assign rsp_pending        = pending_ff;
   assign rsp_new_head       = new_head_ff;
   assign rsp_last           = last_ff;

endmodule
`default_nettype wire

@@ hdl/sorted_timer_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Deadline-ordered timer table with add, delete, query and tick commands.
//
// Usage:
//   req_* carries one command transaction (valid/ready); rsp_* returns its
//   responses (valid/ready), rsp_last marking the final one of a command.
//   Add, delete and query give one response each; a tick gives one response
//   per expired timer, or a single not-expired response when nothing is due.
//   Add, delete and query pass through an accept step, which registers
//   the per-cell deadline and id compares of the cell row, and an execute
//   step that shifts the row and writes the response register. A tick that
//   expires timers pops one head a cycle while no response is stalled.
//   The response register decouples the two sides: a new request is accepted
//   while a response waits, and execution stalls on rsp_valid && !rsp_ready.
//   Reset (synchronous) empties the table and restarts id numbering at zero;
//   the cell contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module sorted_timer_queue #(
   parameter int DEPTH         = 16,
   parameter int DEADLINE_BITS = 32,
   parameter int ID_BITS       = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_deadline,
   input  wire logic [31:0] req_payload,
   input  wire logic [15:0] req_timer_id,
   input  wire logic [31:0] req_now,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_status,
   output logic [15:0]      rsp_result_id,
   output logic [31:0]      rsp_result_payload,
   output logic             rsp_expired,
   output logic             rsp_pending,
   output logic             rsp_new_head,
   output logic             rsp_last
);
   import stq_pkg::*;

   stq_cmd_type    ctrl_cmd;
   stq_status_type ctrl_status;

   stq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .ctrl_status (ctrl_status),
      .ctrl_cmd    (ctrl_cmd)
   );

   stq_datapath #(
      .DEPTH         (DEPTH),
      .DEADLINE_BITS (DEADLINE_BITS),
      .ID_BITS       (ID_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl_cmd           (ctrl_cmd),
      .ctrl_status        (ctrl_status),
      .req_cmd            (req_cmd),
      .req_deadline       (req_deadline),
      .req_payload        (req_payload),
      .req_timer_id       (req_timer_id),
      .req_now            (req_now),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_result_id      (rsp_result_id),
      .rsp_result_payload (rsp_result_payload),
      .rsp_expired        (rsp_expired),
      .rsp_pending        (rsp_pending),
      .rsp_new_head       (rsp_new_head),
      .rsp_last           (rsp_last)
   );

   // one transaction in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a command is in flight");

   a_pop_when_due: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.pop |-> ctrl_status.head_due && ctrl_status.out_free)
      else $error("pop issued without a due head or a free response slot");

   a_insert_not_full: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.ins |-> !ctrl_status.full && ctrl_status.out_free)
      else $error("insert issued into a full table");

   a_response_follows: assert property (@(posedge clock) disable iff (reset)
      ctrl_cmd.out_write |=> rsp_valid)
      else $error("response write not visible on the response channel");

endmodule
`default_nettype wire

@@ tb/sorted_timer_queue_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_tb
// Self-checking bench for the sorted timer queue. A scoreboard keeps its own
// deadline-ordered timer table and predicts every response of add, delete,
// query and tick commands. Directed commands cover empty and full tables,
// extreme deadlines, equal deadlines and not-found ids. Random traffic runs
// with random stalls on both channels, followed by a stall-free stretch.
// ----------------------------------------------------------------------------
module sorted_timer_queue_tb;
   import stq_pkg::*;

   localparam int TABLE_DEPTH    = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_id;
      logic [31:0] result_payload;
      logic        expired;
      logic        pending;
      logic        new_head;
      logic        last;
   } rsp_type;

   class timer_queue_sb;
      logic [31:0] slot_deadline [TABLE_DEPTH];
      logic [15:0] slot_id [TABLE_DEPTH];
      logic [31:0] slot_payload [TABLE_DEPTH];
      int unsigned slot_count;
      logic [15:0] next_id;
      rsp_type     awaited_rsps [$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned expirations;

      function new();
         slot_count  = 0;
         next_id     = '0;
         mismatches  = 0;
         checked     = 0;
         expirations = 0;
      endfunction

      function void expect_rsp(logic [1:0] st, logic [15:0] id, logic [31:0] pay,
                               logic exp, logic pend, logic head, logic fin);
         rsp_type r;
         r = '{st, id, pay, exp, pend, head, fin};
         awaited_rsps.push_back(r);
      endfunction

      function int find_id(logic [15:0] id);
         for (int i = 0; i < slot_count; i++)
            if (slot_id[i] == id)
               return i;
         return -1;
      endfunction

      function void remove_at(int p);
         for (int i = p; i + 1 < slot_count; i++) begin
            slot_deadline[i] = slot_deadline[i + 1];
            slot_id[i]       = slot_id[i + 1];
            slot_payload[i]  = slot_payload[i + 1];
         end
         slot_count--;
      endfunction

      function void note_command(req_op_type cmd, logic [31:0] dl, logic [31:0] pay,
                                 logic [15:0] tid, logic [31:0] now);
         int  p;
         int  n;
         logic fin;
         case (cmd)
            CMD_ADD: begin
               if (slot_count >= TABLE_DEPTH) begin
                  expect_rsp(ST_FULL, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
               end else begin
                  p = 0;
                  while (p < slot_count && slot_deadline[p] < dl)
                     p++;
                  for (int i = slot_count; i > p; i--) begin
                     slot_deadline[i] = slot_deadline[i - 1];
                     slot_id[i]       = slot_id[i - 1];
                     slot_payload[i]  = slot_payload[i - 1];
                  end
                  slot_deadline[p] = dl;
                  slot_id[p]       = next_id;
                  slot_payload[p]  = pay;
                  slot_count++;
                  expect_rsp(ST_OK, next_id, '0, 1'b0, 1'b0, p == 0, 1'b1);
                  next_id++;
               end
            end
            CMD_DELETE: begin
               if (slot_count == 0) begin
                  expect_rsp(ST_EMPTY, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
               end else begin
                  p = find_id(tid);
                  if (p < 0) begin
                     expect_rsp(ST_NOTFOUND, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                  end else begin
                     remove_at(p);
                     expect_rsp(ST_OK, tid, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                  end
               end
            end
            CMD_QUERY: begin
               expect_rsp(ST_OK, '0, '0, 1'b0, find_id(tid) >= 0, 1'b0, 1'b1);
            end
            default: begin
               n = 0;
               while (slot_count > 0 && slot_deadline[0] <= now) begin
                  fin = (slot_count == 1) || (slot_deadline[1] > now);
                  expect_rsp(ST_OK, slot_id[0], slot_payload[0], 1'b1, 1'b0, 1'b0, fin);
                  remove_at(0);
                  expirations++;
                  n++;
               end
               if (n == 0)
                  expect_rsp(ST_OK, '0, '0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
         endcase
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         checked++;
         if (awaited_rsps.size() == 0) begin
            if (mismatches < 10)
               $display("%0t unexpected response: st=%0d id=%h pay=%h exp=%b pend=%b head=%b last=%b",
                        $time, got.status, got.result_id, got.result_payload, got.expired,
                        got.pending, got.new_head, got.last);
            mismatches++;
         end else begin
            want = awaited_rsps.pop_front();
            if (got !== want) begin
               if (mismatches < 10) begin
                  $display("%0t mismatch: exp st=%0d id=%h pay=%h exp=%b pend=%b head=%b last=%b",
                           $time, want.status, want.result_id, want.result_payload,
                           want.expired, want.pending, want.new_head, want.last);
                  $display("%0t           got st=%0d id=%h pay=%h exp=%b pend=%b head=%b last=%b",
                           $time, got.status, got.result_id, got.result_payload, got.expired,
                           got.pending, got.new_head, got.last);
               end
               mismatches++;
            end
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_cmd;
   logic [31:0] req_deadline;
   logic [31:0] req_payload;
   logic [15:0] req_timer_id;
   logic [31:0] req_now;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_result_id;
   logic [31:0] rsp_result_payload;
   logic        rsp_expired;
   logic        rsp_pending;
   logic        rsp_new_head;
   logic        rsp_last;

   timer_queue_sb sb;
   bit            throttle;
   int unsigned   issued;
   int unsigned   quiet_cycles;
   logic [31:0]   window_base;

   sorted_timer_queue u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_deadline       (req_deadline),
      .req_payload        (req_payload),
      .req_timer_id       (req_timer_id),
      .req_now            (req_now),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_result_id      (rsp_result_id),
      .rsp_result_payload (rsp_result_payload),
      .rsp_expired        (rsp_expired),
      .rsp_pending        (rsp_pending),
      .rsp_new_head       (rsp_new_head),
      .rsp_last           (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // response side: random back-pressure, check at the rising edge
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready = !(throttle && $urandom_range(0, 99) < 31);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_result_id, rsp_result_payload, rsp_expired,
                 rsp_pending, rsp_new_head, rsp_last};
         sb.check_response(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("[sorted_timer_queue] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(input req_op_type cmd, input logic [31:0] dl, input logic [31:0] pay,
                       input logic [15:0] tid, input logic [31:0] now);
      while (throttle && $urandom_range(0, 99) < 31) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_cmd      = cmd;
      req_deadline = dl;
      req_payload  = pay;
      req_timer_id = tid;
      req_now      = now;
      req_valid    = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_command(cmd, dl, pay, tid, now);
      issued++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (sb.awaited_rsps.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] pick_deadline();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3:    return $urandom;
         default: return window_base + $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [31:0] pick_now();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return $urandom;
         3, 4, 5: return (sb.slot_count > 0) ?
                          sb.slot_deadline[$urandom_range(0, sb.slot_count - 1)] :
                          window_base;
         default: return window_base + $urandom_range(0, 63);
      endcase
   endfunction

   function automatic logic [15:0] pick_id();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70 && sb.slot_count > 0)
         return sb.slot_id[$urandom_range(0, sb.slot_count - 1)];
      else if (r < 85)
         return sb.next_id - 16'd1;
      else
         return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_random();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 40)
         send(CMD_ADD, pick_deadline(), $urandom, 16'($urandom), $urandom);
      else if (roll < 60)
         send(CMD_DELETE, $urandom, $urandom, pick_id(), $urandom);
      else if (roll < 75)
         send(CMD_QUERY, $urandom, $urandom, pick_id(), $urandom);
      else
         send(CMD_TICK, $urandom, $urandom, 16'($urandom), pick_now());
   endtask

   initial begin
      sb           = new();
      throttle     = 1'b1;
      issued       = 0;
      quiet_cycles = 0;
      window_base  = $urandom_range(0, 32'h7fff_ffff);
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_cmd      = CMD_ADD;
      req_deadline = '0;
      req_payload  = '0;
      req_timer_id = '0;
      req_now      = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed commands
      send(CMD_DELETE, $urandom, $urandom, 16'h0000, $urandom);
      send(CMD_QUERY, $urandom, $urandom, 16'hffff, $urandom);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'hffff_ffff);
      send(CMD_ADD, 32'h0000_0000, 32'h0000_0000, 16'($urandom), $urandom);
      send(CMD_ADD, 32'hffff_ffff, 32'hffff_ffff, 16'($urandom), $urandom);
      send(CMD_ADD, 32'h0000_0000, 32'h5a5a_a5a5, 16'($urandom), $urandom);
      send(CMD_ADD, 32'd100, $urandom, 16'($urandom), $urandom);
      send(CMD_ADD, 32'd100, $urandom, 16'($urandom), $urandom);
      send(CMD_QUERY, $urandom, $urandom, 16'd1, $urandom);
      send(CMD_QUERY, $urandom, $urandom, 16'hffff, $urandom);
      send(CMD_DELETE, $urandom, $urandom, 16'hffff, $urandom);
      send(CMD_DELETE, $urandom, $urandom, 16'd3, $urandom);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'd0);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'd99);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'd100);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'hffff_fffe);
      send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'hffff_ffff);
      send(CMD_DELETE, $urandom, $urandom, 16'd0, $urandom);

      // sender holds off until the queue of responses is empty
      wait_drain();

      for (int n = 0; n < 90; n++) begin
         if (n == 40) begin
            while (sb.slot_count < TABLE_DEPTH)
               send(CMD_ADD, pick_deadline(), $urandom, 16'($urandom), $urandom);
            send(CMD_ADD, pick_deadline(), $urandom, 16'($urandom), $urandom);
            send(CMD_ADD, pick_deadline(), $urandom, 16'($urandom), $urandom);
            send(CMD_QUERY, $urandom, $urandom, pick_id(), $urandom);
            send(CMD_TICK, $urandom, $urandom, 16'($urandom), 32'hffff_ffff);
         end
         if (n == 65)
            wait_drain();
         send_random();
      end

      // random traffic, no stalls on either side
      wait_drain();
      throttle = 1'b0;
      for (int n = 0; n < 20; n++)
         send_random();
      throttle = 1'b1;
      for (int n = 0; n < 10; n++)
         send(CMD_TICK, $urandom, $urandom, 16'($urandom), pick_now());

      wait_drain();
      repeat (20) @(negedge clock);

      $display("%0d commands, %0d responses checked, %0d timers expired, %0d mismatches",
               issued, sb.checked, sb.expirations, sb.mismatches);
      $display("covered empty and full table, equal and extreme deadlines, stall-free traffic");
      if (sb.mismatches == 0 && sb.awaited_rsps.size() == 0) begin
         $display("[sorted_timer_queue] OK");
      end else begin
         $display("[sorted_timer_queue] ERROR");
      end
      $finish;
   end

endmodule
